[rtl/core/m3i_pkg.sv]
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared widths, cofactor operand tables and the queue entry type of the
// 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int unsigned EW             = 32;          // element width
  localparam int unsigned NEL            = 9;           // elements per matrix
  localparam int unsigned NPROD          = 18;          // 2x2 minor products
  localparam int unsigned PW             = 2 * EW;      // product width
  localparam int unsigned CW             = PW + 1;      // cofactor width
  localparam int unsigned DW             = 3 * EW + 1;  // determinant width
  localparam int unsigned QB             = EW + 1;      // quotient bits kept
  localparam int unsigned FRONT_LAT      = 6;
  localparam int unsigned LANE_LAT       = QB + 4;
  localparam int unsigned FIFO_DEPTH_DEF = 4;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // cofactor j = a[PROD_A[2j]]*a[PROD_B[2j]] - a[PROD_A[2j+1]]*a[PROD_B[2j+1]]
  localparam int unsigned PROD_A [NPROD] = '{4, 7, 7, 8, 1, 4, 6, 8, 8,
                                             6, 3, 5, 7, 6, 6, 7, 4, 3};
  localparam int unsigned PROD_B [NPROD] = '{8, 5, 2, 1, 5, 2, 5, 3, 0,
                                             2, 2, 0, 3, 4, 1, 0, 0, 1};
  // first column elements used in the determinant expansion
  localparam int unsigned DET_ROW [3] = '{0, 3, 6};

  typedef logic [NEL-1:0][EW-1:0] m3i_mat_t;

  typedef struct packed {
    logic [NEL-1:0][EW-1:0] elem;
    logic [NEL-1:0][CW-1:0] cof;
    logic [DW-1:0]          det;
    logic                   sing;
  } m3i_entry_t;

endpackage

[rtl/core/matrix3_inverse.sv]
// Pipeline: 6 cofactor/determinant stages, the queue register and 37 divider
// stages incl. output.
// Throughput: one matrix per cycle while the output is not held off; each element
// has its own 33-stage restoring divider retiring one quotient bit per stage.
// Reset clears all valid bits and the queue pointers; no clearing pass.
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 fixed-point matrix inverse via adjugate over determinant, saturating.
// ----------------------------------------------------------------------------
module matrix3_inverse #(
  parameter int unsigned FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF,
  parameter int unsigned FIFO_DEPTH = m3i_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] in_r0c0_i,
  input  logic [31:0] in_r0c1_i,
  input  logic [31:0] in_r0c2_i,
  input  logic [31:0] in_r1c0_i,
  input  logic [31:0] in_r1c1_i,
  input  logic [31:0] in_r1c2_i,
  input  logic [31:0] in_r2c0_i,
  input  logic [31:0] in_r2c1_i,
  input  logic [31:0] in_r2c2_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_r0c0_o,
  output logic [31:0] out_r0c1_o,
  output logic [31:0] out_r0c2_o,
  output logic [31:0] out_r1c0_o,
  output logic [31:0] out_r1c1_o,
  output logic [31:0] out_r1c2_o,
  output logic [31:0] out_r2c0_o,
  output logic [31:0] out_r2c1_o,
  output logic [31:0] out_r2c2_o,
  output logic        singular_o,
  output logic        overflow_o
);
  import m3i_pkg::*;

  m3i_mat_t   in_mat, out_mat;
  m3i_entry_t push_entry, pop_entry;
  logic       fifo_push, fifo_full, fifo_valid, fifo_pop, back_ready;

  assign in_mat = {in_r2c2_i, in_r2c1_i, in_r2c0_i,
                   in_r1c2_i, in_r1c1_i, in_r1c0_i,
                   in_r0c2_i, in_r0c1_i, in_r0c0_i};

  m3i_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .ready_o(in_ready_o),
    .elem_i (in_mat),
    .push_o (fifo_push),
    .entry_o(push_entry),
    .full_i (fifo_full)
  );

  m3i_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .data_i (push_entry),
    .full_o (fifo_full),
    .pop_i  (fifo_pop),
    .valid_o(fifo_valid),
    .data_o (pop_entry)
  );

  assign fifo_pop = fifo_valid && back_ready;

  m3i_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (fifo_valid),
    .ready_o   (back_ready),
    .entry_i   (pop_entry),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .res_o     (out_mat),
    .singular_o(singular_o),
    .overflow_o(overflow_o)
  );

  assign out_r0c0_o = out_mat[0];
  assign out_r0c1_o = out_mat[1];
  assign out_r0c2_o = out_mat[2];
  assign out_r1c0_o = out_mat[3];
  assign out_r1c1_o = out_mat[4];
  assign out_r1c2_o = out_mat[5];
  assign out_r2c0_o = out_mat[6];
  assign out_r2c1_o = out_mat[7];
  assign out_r2c2_o = out_mat[8];

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("queue written while full");

  a_sing_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && singular_o) |-> !overflow_o)
    else $error("overflow flagged on a singular matrix");

endmodule

[rtl/core/m3i_fifo.sv]
// ----------------------------------------------------------------------------
// m3i_fifo
// Short queue between the cofactor front end and the divider back end.
// ----------------------------------------------------------------------------
module m3i_fifo #(
  parameter int unsigned DEPTH = m3i_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  m3i_pkg::m3i_entry_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output m3i_pkg::m3i_entry_t data_o
);
  import m3i_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  m3i_entry_t      mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/core/m3i_div.sv]
// ----------------------------------------------------------------------------
// m3i_div
// One inverse element: rounded cofactor / determinant quotient through a
// one-bit-per-stage restoring divider, then saturation.
// ----------------------------------------------------------------------------
module m3i_div #(
  parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [m3i_pkg::CW-1:0] cof_i,
  input  logic [m3i_pkg::DW-1:0] det_i,
  input  logic [m3i_pkg::EW-1:0] elem_i,
  input  logic                   sing_i,
  output logic [m3i_pkg::EW-1:0] res_o,
  output logic                   ovf_o
);
  import m3i_pkg::*;

  localparam int unsigned SH = 2 * FRAC_BITS + 1;
  localparam int unsigned NW = CW + SH + 1;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned XW = NW + RW;
  localparam logic [QB-1:0] POS_LIM = QB'((64'd1 << (EW - 1)) - 64'd1);
  localparam logic [QB-1:0] NEG_LIM = QB'(64'd1 << (EW - 1));
  localparam logic [EW-1:0] SAT_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] SAT_MIN = {1'b1, {(EW-1){1'b0}}};

  // magnitudes
  logic          neg1_q, sg1_q;
  logic [CW-1:0] cmag1_q;
  logic [DW-1:0] dmag1_q;
  logic [EW-1:0] el1_q;
  // rounded numerator 2|C|*2^(2F) + |D| and divisor 2|D|
  logic          neg2_q, sg2_q;
  logic [NW-1:0] n2_q;
  logic [RW-1:0] v2_q;
  logic [EW-1:0] el2_q;
  // divider stages
  logic [RW-1:0] r_q   [QB+1];
  logic [RW-1:0] v_q   [QB+1];
  logic [QB-1:0] nl_q  [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic          neg_q [QB+1];
  logic          big_q [QB+1];
  logic          sg_q  [QB+1];
  logic [EW-1:0] el_q  [QB+1];

  logic [XW-1:0] nx;
  logic          big;
  logic [RW:0]   r2 [QB];
  logic          ge [QB];
  logic [QB-1:0] qv;
  logic          over;
  logic [EW-1:0] res_d;

  assign nx  = XW'(n2_q) >> QB;
  assign big = (nx >= XW'(v2_q));

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      r2[k] = {r_q[k], nl_q[k][QB-1]};
      ge[k] = (r2[k] >= {1'b0, v_q[k]});
    end
  end

  assign qv   = q_q[QB];
  assign over = big_q[QB] || (neg_q[QB] ? (qv > NEG_LIM) : (qv > POS_LIM));

  always_comb begin
    if (sg_q[QB]) begin
      res_d = el_q[QB];
    end else if (over) begin
      res_d = neg_q[QB] ? SAT_MIN : SAT_MAX;
    end else if (neg_q[QB]) begin
      res_d = EW'(0) - qv[EW-1:0];
    end else begin
      res_d = qv[EW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= cof_i[CW-1] ^ det_i[DW-1];
      cmag1_q <= cof_i[CW-1] ? CW'(-cof_i) : cof_i;
      dmag1_q <= det_i[DW-1] ? DW'(-det_i) : det_i;
      el1_q   <= elem_i;
      sg1_q   <= sing_i;

      neg2_q <= neg1_q;
      n2_q   <= (NW'(cmag1_q) << SH) + NW'(dmag1_q);
      v2_q   <= {dmag1_q, 1'b0};
      el2_q  <= el1_q;
      sg2_q  <= sg1_q;

      // quotient above QB bits shows up as big
      r_q[0]   <= RW'(nx);
      v_q[0]   <= v2_q;
      nl_q[0]  <= n2_q[QB-1:0];
      q_q[0]   <= '0;
      neg_q[0] <= neg2_q;
      big_q[0] <= big;
      sg_q[0]  <= sg2_q;
      el_q[0]  <= el2_q;

      for (int k = 1; k <= QB; k++) begin
        r_q[k]   <= ge[k-1] ? RW'(r2[k-1] - {1'b0, v_q[k-1]}) : RW'(r2[k-1]);
        v_q[k]   <= v_q[k-1];
        nl_q[k]  <= nl_q[k-1] << 1;
        q_q[k]   <= {q_q[k-1][QB-2:0], ge[k-1]};
        neg_q[k] <= neg_q[k-1];
        big_q[k] <= big_q[k-1];
        sg_q[k]  <= sg_q[k-1];
        el_q[k]  <= el_q[k-1];
      end

      res_o <= res_d;
      ovf_o <= !sg_q[QB] && over;
    end
  end

endmodule

[rtl/core/m3i_front.sv]
// ----------------------------------------------------------------------------
// m3i_front
// Accepts a matrix, forms the nine cofactors and the determinant and flags a
// singular matrix before it goes into the queue.
// ----------------------------------------------------------------------------
module m3i_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  m3i_pkg::m3i_mat_t   elem_i,
  output logic                push_o,
  output m3i_pkg::m3i_entry_t entry_o,
  input  logic                full_i
);
  import m3i_pkg::*;

  logic                 en;
  logic [FRONT_LAT-1:0] vld_q;

  m3i_mat_t             a1_q, a2_q, a3_q, a4_q, a5_q, a6_q;
  logic signed [PW-1:0] p2_q  [NPROD];
  logic signed [CW-1:0] t3_q  [NEL];
  logic signed [CW-1:0] t4_q  [NEL];
  logic signed [CW-1:0] t5_q  [NEL];
  logic signed [CW-1:0] t6_q  [NEL];
  logic signed [CW-1:0] pl4_q [3];
  logic signed [CW-1:0] ph4_q [3];
  logic signed [DW-1:0] dp5_q [3];
  logic signed [DW-1:0] det6_q;

  assign en      = !vld_q[FRONT_LAT-1] || !full_i;
  assign ready_o = en;
  assign push_o  = vld_q[FRONT_LAT-1] && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[FRONT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q <= elem_i;
      a2_q <= a1_q;
      a3_q <= a2_q;
      a4_q <= a3_q;
      a5_q <= a4_q;
      a6_q <= a5_q;
      for (int k = 0; k < NPROD; k++) begin
        p2_q[k] <= $signed(a1_q[PROD_A[k]]) * $signed(a1_q[PROD_B[k]]);
      end
      for (int j = 0; j < NEL; j++) begin
        t3_q[j] <= CW'(p2_q[2*j]) - CW'(p2_q[2*j+1]);
      end
      t4_q <= t3_q;
      t5_q <= t4_q;
      t6_q <= t5_q;
      // 32 x 65 product split into low and high partial products
      for (int k = 0; k < 3; k++) begin
        pl4_q[k] <= $signed(a3_q[DET_ROW[k]]) * $signed({1'b0, t3_q[k][EW-1:0]});
        ph4_q[k] <= $signed(a3_q[DET_ROW[k]]) * $signed(t3_q[k][CW-1:EW]);
        dp5_q[k] <= (DW'(ph4_q[k]) <<< EW) + DW'(pl4_q[k]);
      end
      det6_q <= dp5_q[0] + dp5_q[1] + dp5_q[2];
    end
  end

  always_comb begin
    entry_o.elem = a6_q;
    for (int j = 0; j < NEL; j++) begin
      entry_o.cof[j] = t6_q[j];
    end
    entry_o.det  = det6_q;
    entry_o.sing = (det6_q == '0);
  end

endmodule

[rtl/core/m3i_back.sv]
// ----------------------------------------------------------------------------
// m3i_back
// Nine divider lanes driven by one stall-able pipeline; the last lane stage
// is the output register.
// ----------------------------------------------------------------------------
module m3i_back #(
  parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  m3i_pkg::m3i_entry_t entry_i,
  output logic                valid_o,
  input  logic                ready_i,
  output m3i_pkg::m3i_mat_t   res_o,
  output logic                singular_o,
  output logic                overflow_o
);
  import m3i_pkg::*;

  logic                en;
  logic [LANE_LAT-1:0] vld_q;
  logic [LANE_LAT-1:0] sg_q;
  logic [NEL-1:0]      ovf;

  assign en         = !vld_q[LANE_LAT-1] || ready_i;
  assign ready_o    = en;
  assign valid_o    = vld_q[LANE_LAT-1];
  assign singular_o = sg_q[LANE_LAT-1];
  assign overflow_o = |ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      sg_q  <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LANE_LAT-2:0], valid_i};
      sg_q  <= {sg_q[LANE_LAT-2:0], entry_i.sing};
    end
  end

  for (genvar i = 0; i < NEL; i++) begin : g_lane
    m3i_div #(
      .FRAC_BITS(FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .cof_i (entry_i.cof[i]),
      .det_i (entry_i.det),
      .elem_i(entry_i.elem[i]),
      .sing_i(entry_i.sing),
      .res_o (res_o[i]),
      .ovf_o (ovf[i])
    );
  end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse testbench
// Drives 3x3 Q16.16 matrices through the valid/ready input, predicts the
// saturated adjugate/determinant inverse in wide integer math and checks
// every result in order, with random idling on both sides and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = m3i_pkg::FRAC_BITS_DEF;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          DRAIN_CYCLES = 200;

  typedef logic signed [31:0] elem_t;
  typedef elem_t mat_t [9];

  typedef struct {
    logic [31:0] el [9];
    logic        singular;
    logic        overflow;
  } inverse_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] in_el [9];
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] out_el [9];
  logic        singular_o;
  logic        overflow_o;

  inverse_t    expected_q [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          in_idle_pct = 30;
  int          out_idle_pct = 30;
  int          hold_off = 0;
  bit          timed_out = 1'b0;

  initial for (int i = 0; i < 9; i++) in_el[i] = '0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  matrix3_inverse dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_r0c0_i   (in_el[0]),
    .in_r0c1_i   (in_el[1]),
    .in_r0c2_i   (in_el[2]),
    .in_r1c0_i   (in_el[3]),
    .in_r1c1_i   (in_el[4]),
    .in_r1c2_i   (in_el[5]),
    .in_r2c0_i   (in_el[6]),
    .in_r2c1_i   (in_el[7]),
    .in_r2c2_i   (in_el[8]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_r0c0_o  (out_el[0]),
    .out_r0c1_o  (out_el[1]),
    .out_r0c2_o  (out_el[2]),
    .out_r1c0_o  (out_el[3]),
    .out_r1c1_o  (out_el[4]),
    .out_r1c2_o  (out_el[5]),
    .out_r2c0_o  (out_el[6]),
    .out_r2c1_o  (out_el[7]),
    .out_r2c2_o  (out_el[8]),
    .singular_o  (singular_o),
    .overflow_o  (overflow_o)
  );

  // exact inverse: cofactors, determinant and quotient all carried at 160 bits
  function automatic inverse_t invert_matrix(mat_t m);
    inverse_t                res;
    logic signed [159:0]     a [9];
    logic signed [159:0]     cf [9];
    logic signed [159:0]     det, num, dmag, q;
    bit                      neg;
    for (int i = 0; i < 9; i++) a[i] = m[i];
    cf[0] = a[4] * a[8] - a[7] * a[5];
    cf[1] = a[7] * a[2] - a[8] * a[1];
    cf[2] = a[1] * a[5] - a[4] * a[2];
    cf[3] = a[6] * a[5] - a[8] * a[3];
    cf[4] = a[8] * a[0] - a[6] * a[2];
    cf[5] = a[3] * a[2] - a[5] * a[0];
    cf[6] = a[7] * a[3] - a[6] * a[4];
    cf[7] = a[6] * a[1] - a[7] * a[0];
    cf[8] = a[4] * a[0] - a[3] * a[1];
    det = a[0] * cf[0] + a[3] * cf[1] + a[6] * cf[2];
    res.singular = (det == 0);
    res.overflow = 1'b0;
    if (res.singular) begin
      for (int i = 0; i < 9; i++) res.el[i] = m[i];
      return res;
    end
    dmag = (det < 0) ? -det : det;
    for (int i = 0; i < 9; i++) begin
      neg = (cf[i] < 0) != (det < 0);
      num = (cf[i] < 0) ? -cf[i] : cf[i];
      // round half away from zero on magnitudes
      q = ((num <<< (2 * FRAC + 1)) + dmag) / (dmag <<< 1);
      if (!neg) begin
        if (q > 160'sh7FFF_FFFF) begin
          res.el[i] = 32'h7FFF_FFFF;
          res.overflow = 1'b1;
        end else begin
          res.el[i] = q[31:0];
        end
      end else begin
        if (q > 160'sh8000_0000) begin
          res.el[i] = 32'h8000_0000;
          res.overflow = 1'b1;
        end else begin
          res.el[i] = -q[31:0];
        end
      end
    end
    return res;
  endfunction

  task automatic send_matrix(mat_t m);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 9; i++) in_el[i] <= m[i];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(invert_matrix(m));
  endtask

  // receiver: random stalls plus a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    inverse_t exp_inv;
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_inv = expected_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (out_el[i] !== exp_inv.el[i]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("element %0d: expected %h, got %h", i, exp_inv.el[i], out_el[i]);
          end
        end
        if (singular_o !== exp_inv.singular || overflow_o !== exp_inv.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("flags singular/overflow: expected %b%b, got %b%b",
                     exp_inv.singular, exp_inv.overflow, singular_o, overflow_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else if (in_valid_i || expected_q.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("** matrix3_inverse: FAILED **");
      $finish;
    end
  end

  function automatic elem_t rand_elem();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $signed($urandom_range(8)) - 4;
      2:       return elem_t'(32'h8000_0000) + $urandom_range(2);
      3:       return elem_t'(32'h7FFF_FFFF) - $urandom_range(2);
      default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic mat_t scaled_identity(elem_t v);
    mat_t m;
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? v : 0;
    return m;
  endfunction

  task automatic test_directed();
    mat_t m;
    send_matrix(scaled_identity(32'sh0001_0000));
    send_matrix(scaled_identity(32'sh0002_0000));
    send_matrix(scaled_identity(-32'sh0001_0000));
    send_matrix(scaled_identity(32'sh7FFF_FFFF));
    send_matrix(scaled_identity(elem_t'(32'h8000_0000)));
    send_matrix(scaled_identity(1));
    send_matrix(scaled_identity(-1));
    send_matrix(scaled_identity(0));
    for (int i = 0; i < 9; i++) m[i] = 32'h8000_0000;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = 32'hFFFF_FFFF;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = 32'h7FFF_FFFF;
    send_matrix(m);
    // rank-one matrix, singular with nonzero elements
    for (int i = 0; i < 9; i++) m[i] = (i / 3 + 1) * (i % 3 + 1) * 32'sh0001_0000;
    send_matrix(m);
    // permutation and alternating extremes
    m = scaled_identity(0);
    m[1] = 32'sh0001_0000; m[5] = -32'sh0001_0000; m[6] = 32'sh0000_8000;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 32'h5555_5555 : 32'hAAAA_AAAA;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = $urandom;
    send_matrix(m);
  endtask

  task automatic test_random(int count);
    mat_t m;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++) m[i] = rand_elem();
      // occasionally force a singular matrix by copying a row
      if ($urandom_range(9) == 0)
        for (int c = 0; c < 3; c++) m[6 + c] = m[c];
      send_matrix(m);
    end
  endtask

  task automatic test_no_idle(int count);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random(count);
    in_idle_pct = 30;
    out_idle_pct = 30;
  endtask

  task automatic test_backpressure(int count);
    in_idle_pct = 0;
    hold_off = 150;
    test_random(count);
    in_idle_pct = 30;
  endtask

  initial begin
    int drain;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400);
    test_no_idle(200);
    test_backpressure(60);
    test_random(140);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk_i);
      drain++;
    end
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("** matrix3_inverse: PASSED **");
    end else begin
      $display("** matrix3_inverse: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/m3i_pkg.sv
rtl/core/m3i_fifo.sv
rtl/core/m3i_div.sv
rtl/core/m3i_front.sv
rtl/core/m3i_back.sv
rtl/core/matrix3_inverse.sv
sim/testbench.sv
